// ----- design/wmft_pkg.sv -----
// Package for the window mode frequency tracker.
// Sizes, result status codes and the controller/datapath command and status types.
// No dependencies.
package wmft_pkg;

  // Table sizes
  localparam int VALUE_COUNT = 1024;
  localparam int MAX_COUNT   = 4096;
  localparam int HIST_DEPTH  = MAX_COUNT + 1;

  // Field and storage widths
  localparam int VAL_W = $clog2(VALUE_COUNT);
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int VAM_W = $clog2(VALUE_COUNT + 1);
  localparam int ST_W  = 2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT  = 2'd2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;       // write zero at the sweep address and advance
    logic load;      // capture transaction, read count table
    logic rd_h1;     // clamp count, set status, read histogram at old count
    logic upd1;      // retire old count, write count table, read new count entry
    logic upd2;      // bump histogram at new count
    logic rd_top;    // read histogram at the current maximum
    logic out_load;  // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last histogram entry
    logic item_err;  // transaction is ignored (absent removal or count limit)
    logic to_zero;   // removal leaves the value with count zero
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

// ----- design/wmft_ctrl.sv -----
// Controller state machine for the window mode frequency tracker.
// Sequences the clearing sweep and the per-transaction memory accesses.
// Depends on wmft_pkg.
module wmft_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wmft_pkg::stat_t stat_i,
  output wmft_pkg::cmd_t  cmd_o
);
  import wmft_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDC   = 7'b0000100,
    S_RDH1  = 7'b0001000,
    S_RDH2  = 7'b0010000,
    S_RDTOP = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RDC;
        end
      end
      S_RDC: begin
        cmd_o.rd_h1 = 1'b1;
        state_d     = stat_i.item_err ? S_RDTOP : S_RDH1;
      end
      S_RDH1: begin
        cmd_o.upd1 = 1'b1;
        state_d    = stat_i.to_zero ? S_RDTOP : S_RDH2;
      end
      S_RDH2: begin
        cmd_o.upd2 = 1'b1;
        state_d    = S_RDTOP;
      end
      S_RDTOP: begin
        cmd_o.rd_top = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // hold the read result until the output slot frees up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- design/wmft_datapath.sv -----
// Datapath for the window mode frequency tracker.
// Holds the count table and count histogram memories, the maximum count and the result register.
// Depends on wmft_pkg.
module wmft_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wmft_pkg::cmd_t              cmd_i,
  output wmft_pkg::stat_t             stat_o,
  input  logic                        func_i,
  input  logic [wmft_pkg::VAL_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wmft_pkg::CNT_W-1:0]  max_count_o,
  output logic [wmft_pkg::VAM_W-1:0]  values_at_max_o,
  output logic [wmft_pkg::ST_W-1:0]   status_o
);
  import wmft_pkg::*;

  // Memories
  logic [CNT_W-1:0] ct_mem   [VALUE_COUNT];
  logic [VAM_W-1:0] hist_mem [HIST_DEPTH];

  // Control registers
  logic [CNT_W-1:0] clr_addr_q;
  logic [CNT_W-1:0] top_q, top_d;
  logic             out_valid_q;

  // Transaction registers
  logic             func_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] c_q, c_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic [CNT_W-1:0] ct_rd_q;
  logic [VAM_W-1:0] hist_rd_q;
  logic [CNT_W-1:0] max_q;
  logic [VAM_W-1:0] vam_q;
  logic [ST_W-1:0]  rst_st_q;

  // Memory port signals
  logic             ct_we;
  logic [VAL_W-1:0] ct_wa;
  logic [CNT_W-1:0] ct_wd;
  logic             ct_re;
  logic             hist_we;
  logic [CNT_W-1:0] hist_wa;
  logic [VAM_W-1:0] hist_wd;
  logic             hist_re;
  logic [CNT_W-1:0] hist_ra;

  logic [CNT_W-1:0] c_clamp;
  logic [ST_W-1:0]  st_calc;
  logic [VAM_W-1:0] h1_dec;
  logic [CNT_W-1:0] c_next;
  logic             clr_in_ct;

  // Count read back, clamped to the limit
  assign c_clamp = (ct_rd_q > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : ct_rd_q;

  // Status of the transaction
  always_comb begin
    st_calc = ST_OK;
    if (func_q == OP_REMOVE) begin
      if (c_clamp == '0) st_calc = ST_ABSENT;
    end else begin
      if (c_clamp >= CNT_W'(MAX_COUNT)) st_calc = ST_LIMIT;
    end
  end

  // Old count entry retired, new count
  assign h1_dec = (hist_rd_q != '0) ? hist_rd_q - VAM_W'(1) : hist_rd_q;
  assign c_next = (func_q == OP_REMOVE) ? c_q - CNT_W'(1) : c_q + CNT_W'(1);

  assign clr_in_ct = (clr_addr_q < CNT_W'(VALUE_COUNT));

  // Memory port selection
  always_comb begin
    ct_we   = 1'b0;
    ct_wa   = val_q;
    ct_wd   = c_next;
    ct_re   = cmd_i.load;
    hist_we = 1'b0;
    hist_wa = c_q;
    hist_wd = h1_dec;
    hist_re = 1'b0;
    hist_ra = top_q;
    if (cmd_i.clr) begin
      ct_we   = clr_in_ct;
      ct_wa   = clr_addr_q[VAL_W-1:0];
      ct_wd   = '0;
      hist_we = 1'b1;
      hist_wa = clr_addr_q;
      hist_wd = '0;
    end else if (cmd_i.rd_h1) begin
      hist_re = 1'b1;
      hist_ra = c_clamp;
    end else if (cmd_i.upd1) begin
      ct_we   = 1'b1;
      // an insert from zero has no histogram entry to retire
      hist_we = (func_q == OP_REMOVE) || (c_q != '0);
      hist_re = 1'b1;
      hist_ra = c_next;
    end else if (cmd_i.upd2) begin
      hist_we = 1'b1;
      hist_wd = hist_rd_q + VAM_W'(1);
    end else if (cmd_i.rd_top) begin
      hist_re = 1'b1;
      hist_ra = top_q;
    end
  end

  // Count table memory
  always_ff @(posedge clk_i) begin
    if (ct_we) ct_mem[ct_wa] <= ct_wd;
    if (ct_re) ct_rd_q <= ct_mem[value_i];
  end

  // Count histogram memory
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd_q <= hist_mem[hist_ra];
  end

  // Maximum count and working count updates
  always_comb begin
    top_d = top_q;
    c_d   = c_q;
    st_d  = st_q;
    if (cmd_i.rd_h1) begin
      c_d  = c_clamp;
      st_d = st_calc;
    end
    if (cmd_i.upd1) begin
      c_d = c_next;
      // last value at the top count removed: the maximum drops by one
      if ((func_q == OP_REMOVE) && (h1_dec == '0) && (c_q == top_q) && (top_q != '0)) begin
        top_d = top_q - CNT_W'(1);
      end
    end
    if (cmd_i.upd2 && (func_q == OP_INSERT) && (c_q > top_q)) begin
      top_d = c_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr && (clr_addr_q != CNT_W'(MAX_COUNT))) begin
        clr_addr_q <= clr_addr_q + CNT_W'(1);
      end
      top_q <= top_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Transaction and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      val_q  <= value_i;
    end
    c_q  <= c_d;
    st_q <= st_d;
    if (cmd_i.out_load) begin
      max_q    <= top_q;
      vam_q    <= (top_q != '0) ? hist_rd_q : '0;
      rst_st_q <= st_q;
    end
  end

  assign stat_o.clr_last = (clr_addr_q == CNT_W'(MAX_COUNT));
  assign stat_o.item_err = (st_calc != ST_OK);
  assign stat_o.to_zero  = (func_q == OP_REMOVE) && (c_q == CNT_W'(1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign max_count_o     = max_q;
  assign values_at_max_o = vam_q;
  assign status_o        = rst_st_q;

endmodule

// ----- design/window_mode_frequency_tracker.sv -----
// Top level of the window mode frequency tracker.
// Joins the controller (wmft_ctrl) and the datapath (wmft_datapath); depends on wmft_pkg.
//
// Tracks a multiset of values one insert or removal at a time and reports, for each
// transaction, the highest occurrence count and how many distinct values share it
// (both zero for an empty window). A removal of an absent value or an insert at the
// count limit changes nothing and is flagged in status. After reset the block sweeps
// both tables to zero, one entry a cycle, stalling input meanwhile. Each transaction
// then runs a chain of dependent reads and writes on the single-read-port histogram
// memory; a removal that leaves the value absent skips the bump at the new count, and
// an ignored transaction skips both updates. The result sits in an output register;
// a stalled result holds the next one in the controller.
module window_mode_frequency_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [wmft_pkg::VAL_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wmft_pkg::CNT_W-1:0]  max_count_o,
  output logic [wmft_pkg::VAM_W-1:0]  values_at_max_o,
  output logic [wmft_pkg::ST_W-1:0]   status_o
);
  import wmft_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  wmft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Tables and result
  wmft_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (func_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .max_count_o     (max_count_o),
    .values_at_max_o (values_at_max_o),
    .status_o        (status_o)
  );

endmodule
